// ===== hdl/mma_pkg.sv =====
// Shared types and constants of the masked moving average block.
// Holds the configuration register codes, the controller state type and the
// control word that drives the row of storage cells. Depends on nothing.
`default_nettype none

package mma_pkg;

    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_HALF = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOICED_ONLY = 1'b1;

    localparam logic [CFG_DATA_W-1:0] RESET_WINDOW_HALF = 4'd2;
    localparam logic                  RESET_VOICED_ONLY = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PUSH   = 6'b000010,
        ST_SWEEP  = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    typedef struct packed {
        logic fill;
        logic advance;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/mma_cell.sv =====
// One storage cell of the sample line: holds a single sample and takes its
// neighbour's value when the line advances, or the fill value when loaded.
// Depends on mma_pkg for the cell control word.
`default_nettype none

module mma_cell #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                   aclk,
    input  wire mma_pkg::cell_ctrl_t    ctrl,
    input  wire logic [SAMPLE_BITS-1:0] fill_value,
    input  wire logic [SAMPLE_BITS-1:0] shift_in,
    output logic      [SAMPLE_BITS-1:0] value
);

    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctrl.fill) begin
            value_next = fill_value;
        end else if (ctrl.advance) begin
            value_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== hdl/mma_div.sv =====
// Iterative restoring divider producing one quotient bit per cycle.
// Divides an unsigned magnitude by a narrow unsigned divisor; no package use.
`default_nettype none

module mma_div #(
    parameter int MAG_W = 28,
    parameter int DIV_W = 5
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic      [MAG_W-1:0] quotient
);

    localparam int ITER_W = $clog2(MAG_W + 1);

    logic              active_reg;
    logic              active_next;
    logic              done_reg;
    logic              done_next;
    logic [MAG_W-1:0]  quo_reg;
    logic [MAG_W-1:0]  quo_next;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;
    logic [DIV_W:0]    trial;
    logic              last_iter;

    always_comb begin
        trial       = {rem_reg, quo_reg[MAG_W-1]};
        last_iter   = active_reg && (iter_reg == ITER_W'(MAG_W - 1));
        active_next = active_reg;
        done_next   = last_iter;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        iter_next   = iter_reg;
        if (start) begin
            active_next = 1'b1;
            quo_next    = dividend;
            rem_next    = '0;
            iter_next   = '0;
        end else if (active_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = DIV_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            iter_next = iter_reg + ITER_W'(1);
            if (last_iter) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        iter_reg <= iter_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/masked_moving_average.sv =====
// Top level of the masked moving average: control, row of sample cells,
// accumulator and divider. Depends on mma_pkg, mma_cell and mma_div.
//
// Usage: samples arrive on the s_ channel (valid/ready) with s_last marking
// the final word of a sequence; smoothed words leave on the m_ channel, one
// per input sample, with m_final_res high on the last word of the sequence.
// Each output is the rounded mean of the 2h+1 samples centred on it, with the
// first and last samples replicated past the ends; with voiced_only set, only
// positive samples are averaged and non-positive ones pass through unchanged.
// window_half and voiced_only are written on the cfg port and take effect at
// the start of the next sequence.
// Per result: a rotation of the cell row (ST_SWEEP), a check (ST_CHECK),
// the bit-serial divider with collection of its quotient (ST_DIVIDE) and a
// load of the output register (ST_DONE); a passed-through word goes from the
// check straight to the load. The block takes no new word until the result of
// the previous one is loaded and it is back in ST_IDLE. The last word of a
// sequence yields up to h further results, each after a push in ST_PUSH. A word
// that yields no result leaves the block in ST_IDLE, ready for the next word.
// A finished result waits in the output register while the receiver stalls;
// the next result waits in turn until that register is free.
// Reset empties the output, closes any open sequence and restores the
// configuration defaults (h = 2, voiced_only = 1).
`default_nettype none

module masked_moving_average #(
    parameter int MAX_HALF    = 15,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mma_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mma_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]   s_sample,
    input  wire logic                            s_last,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_smoothed,
    output logic                                 m_final_res
);

    localparam int DEPTH  = 2 * MAX_HALF + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int HALF_W = $clog2(MAX_HALF + 1);
    localparam int FILL_W = $clog2(MAX_HALF + 2);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W;
    localparam int MAG_W  = SUM_W - 1;

    logic [mma_pkg::CFG_DATA_W-1:0] win_half_reg;
    logic [mma_pkg::CFG_DATA_W-1:0] win_half_next;
    logic                           voiced_cfg_reg;
    logic                           voiced_cfg_next;

    mma_pkg::state_t state_reg;
    mma_pkg::state_t state_next;

    logic                          started_reg;
    logic                          started_next;
    logic [FILL_W-1:0]             fill_reg;
    logic [FILL_W-1:0]             fill_next;
    logic                          last_mode_reg;
    logic                          last_mode_next;
    logic [HALF_W-1:0]             flush_reg;
    logic [HALF_W-1:0]             flush_next;
    logic [HALF_W-1:0]             half_reg;
    logic [HALF_W-1:0]             half_next;
    logic                          voiced_reg;
    logic                          voiced_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] x_next;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic signed [SAMPLE_BITS-1:0] center_reg;
    logic signed [SAMPLE_BITS-1:0] center_next;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    logic signed [SAMPLE_BITS-1:0] res_next;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_smoothed_reg;
    logic signed [SAMPLE_BITS-1:0] m_smoothed_next;
    logic                          m_final_reg;
    logic                          m_final_next;

    logic                   accept;
    logic [HALF_W-1:0]      h_start;
    logic [HALF_W-1:0]      h_use;
    logic [FILL_W-1:0]      thr;
    logic [FILL_W-1:0]      fill_step;
    logic [IDX_W-1:0]       two_h;
    logic [SAMPLE_BITS-1:0] tap;
    logic                   tap_voiced;
    logic                   tap_in;
    logic [SUM_W-1:0]       abs_sum;
    logic [MAG_W-1:0]       div_dividend;
    logic                   div_start;
    logic                   div_done;
    logic [MAG_W-1:0]       div_quotient;
    logic [SAMPLE_BITS-1:0] quo_low;

    mma_pkg::cell_ctrl_t    cell_ctrl;
    logic [SAMPLE_BITS-1:0] cell_head;
    logic [SAMPLE_BITS-1:0] tap_q [DEPTH];

    // Row of cells: cell 0 takes the newest word, the last cell holds the oldest.
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        if (j == 0) begin : g_head
            mma_cell #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl),
                .fill_value(s_sample),
                .shift_in  (cell_head),
                .value     (tap_q[j])
            );
        end else begin : g_body
            mma_cell #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl),
                .fill_value(s_sample),
                .shift_in  (tap_q[j-1]),
                .value     (tap_q[j])
            );
        end
    end

    mma_div #(
        .MAG_W(MAG_W),
        .DIV_W(CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        accept = s_valid && s_ready;

        if (int'(win_half_reg) > MAX_HALF) begin
            h_start = HALF_W'(MAX_HALF);
        end else begin
            h_start = HALF_W'(win_half_reg);
        end
        h_use     = ((state_reg == mma_pkg::ST_IDLE) && !started_reg) ? h_start : half_reg;
        thr       = FILL_W'(h_use) + FILL_W'(1);
        fill_step = (fill_reg < thr) ? (fill_reg + FILL_W'(1)) : fill_reg;
        two_h     = IDX_W'({half_reg, 1'b0});

        // During the rotation the oldest cell presents each tap in turn.
        tap        = tap_q[DEPTH-1];
        tap_voiced = !tap[SAMPLE_BITS-1] && (tap != '0);
        tap_in     = (idx_reg <= two_h) && (!voiced_reg || tap_voiced);

        abs_sum      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        div_dividend = abs_sum[MAG_W-1:0] + MAG_W'(cnt_reg >> 1);
        quo_low      = div_quotient[SAMPLE_BITS-1:0];

        win_half_next   = win_half_reg;
        voiced_cfg_next = voiced_cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                mma_pkg::CFG_WINDOW_HALF: begin
                    win_half_next = cfg_wdata;
                end
                mma_pkg::CFG_VOICED_ONLY: begin
                    voiced_cfg_next = cfg_wdata[0];
                end
                default: begin
                    win_half_next = win_half_reg;
                end
            endcase
        end

        state_next      = state_reg;
        started_next    = started_reg;
        fill_next       = fill_reg;
        last_mode_next  = last_mode_reg;
        flush_next      = flush_reg;
        half_next       = half_reg;
        voiced_next     = voiced_reg;
        x_next          = x_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        center_next     = center_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_smoothed_next = m_smoothed_reg;
        m_final_next    = m_final_reg;
        div_start       = 1'b0;
        cell_ctrl       = '0;
        cell_head       = s_sample;

        case (state_reg)
            mma_pkg::ST_IDLE: begin
                if (accept) begin
                    x_next         = s_sample;
                    last_mode_next = s_last;
                    flush_next     = s_last ? h_use : '0;
                    if (!started_reg) begin
                        started_next   = 1'b1;
                        half_next      = h_start;
                        voiced_next    = voiced_cfg_reg;
                        fill_next      = FILL_W'(1);
                        cell_ctrl.fill = 1'b1;
                    end else begin
                        fill_next         = fill_step;
                        cell_ctrl.advance = 1'b1;
                    end
                    if (fill_next >= thr) begin
                        idx_next   = IDX_W'(DEPTH - 1);
                        sum_next   = '0;
                        cnt_next   = '0;
                        state_next = mma_pkg::ST_SWEEP;
                    end else if (s_last) begin
                        state_next = mma_pkg::ST_PUSH;
                    end
                end
            end
            mma_pkg::ST_PUSH: begin
                cell_head         = x_reg;
                cell_ctrl.advance = 1'b1;
                fill_next         = fill_step;
                flush_next        = flush_reg - HALF_W'(1);
                if (fill_step >= thr) begin
                    idx_next   = IDX_W'(DEPTH - 1);
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = mma_pkg::ST_SWEEP;
                end
            end
            mma_pkg::ST_SWEEP: begin
                cell_head         = tap;
                cell_ctrl.advance = 1'b1;
                if (tap_in) begin
                    sum_next = sum_reg + SUM_W'(signed'(tap));
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (idx_reg == IDX_W'(half_reg)) begin
                    center_next = tap;
                end
                if (idx_reg == '0) begin
                    state_next = mma_pkg::ST_CHECK;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            mma_pkg::ST_CHECK: begin
                if (voiced_reg && !(center_reg > 0)) begin
                    res_next   = center_reg;
                    state_next = mma_pkg::ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = mma_pkg::ST_DIVIDE;
                end
            end
            mma_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    res_next   = sum_reg[SUM_W-1] ? -quo_low : quo_low;
                    state_next = mma_pkg::ST_DONE;
                end
            end
            mma_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_smoothed_next = res_reg;
                    m_final_next    = last_mode_reg && (flush_reg == '0);
                    if (last_mode_reg && (flush_reg != '0)) begin
                        state_next = mma_pkg::ST_PUSH;
                    end else begin
                        if (last_mode_reg) begin
                            started_next   = 1'b0;
                            fill_next      = '0;
                            last_mode_next = 1'b0;
                        end
                        state_next = mma_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = mma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_half_reg   <= mma_pkg::RESET_WINDOW_HALF;
            voiced_cfg_reg <= mma_pkg::RESET_VOICED_ONLY;
            state_reg      <= mma_pkg::ST_IDLE;
            started_reg    <= 1'b0;
            fill_reg       <= '0;
            last_mode_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            win_half_reg   <= win_half_next;
            voiced_cfg_reg <= voiced_cfg_next;
            state_reg      <= state_next;
            started_reg    <= started_next;
            fill_reg       <= fill_next;
            last_mode_reg  <= last_mode_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        flush_reg      <= flush_next;
        half_reg       <= half_next;
        voiced_reg     <= voiced_next;
        x_reg          <= x_next;
        idx_reg        <= idx_next;
        sum_reg        <= sum_next;
        cnt_reg        <= cnt_next;
        center_reg     <= center_next;
        res_reg        <= res_next;
        m_smoothed_reg <= m_smoothed_next;
        m_final_reg    <= m_final_next;
    end

    assign s_ready     = (state_reg == mma_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_smoothed  = m_smoothed_reg;
    assign m_final_res = m_final_reg;

endmodule

`default_nettype wire

// ===== tb/masked_moving_average_tb.sv =====
// Self-checking testbench for masked_moving_average: random and directed pitch sequences,
// several window and voicing settings, random stalls on both channels, scoreboard prediction.
// Depends on mma_pkg and the masked_moving_average RTL only.
`timescale 1ns / 100ps

module masked_moving_average_tb;

    localparam int MAX_HALF       = 15;
    localparam int SAMPLE_BITS    = 24;
    localparam int LINE_DEPTH     = 2 * MAX_HALF + 1;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 248;
    localparam int CFG_W          = mma_pkg::CFG_DATA_W;
    localparam int CFG_IDX_W      = mma_pkg::CFG_INDEX_W;

    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = 24'h7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = 24'h800000;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic                          final_res;
    } smoothed_word_t;

    class pitch_smoother_board;
        logic [CFG_W-1:0] reg_half;
        logic             reg_voiced;
        int               run_half;
        bit               run_voiced;
        bit               seq_open;
        int               fill;
        longint           taps[LINE_DEPTH];
        smoothed_word_t   expected_words[$];
        int               errors;
        int               sequences;
        int               averaged;
        int               passed;

        function new();
            reg_half   = mma_pkg::RESET_WINDOW_HALF;
            reg_voiced = mma_pkg::RESET_VOICED_ONLY;
            seq_open   = 1'b0;
            fill       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            if (index == mma_pkg::CFG_WINDOW_HALF) begin
                reg_half = data;
            end else begin
                reg_voiced = data[0];
            end
        endfunction

        function void shift_in(longint x);
            for (int i = 0; i < 2 * run_half; i++) begin
                taps[i] = taps[i + 1];
            end
            taps[2 * run_half] = x;
        endfunction

        function void predict_word();
            smoothed_word_t word;
            longint         centre;
            longint         total;
            longint         mag;
            longint         quot;
            longint         res;
            int             count;

            centre = taps[run_half];
            if (run_voiced && centre <= 0) begin
                res = centre;
                passed++;
            end else begin
                total = 0;
                count = 0;
                for (int i = 0; i <= 2 * run_half; i++) begin
                    if (!run_voiced || taps[i] > 0) begin
                        total += taps[i];
                        count++;
                    end
                end
                if (count == 0) begin
                    count = 1;
                end
                mag  = (total < 0) ? -total : total;
                quot = (mag + count / 2) / count;
                res  = (total < 0) ? -quot : quot;
                averaged++;
            end
            word.smoothed  = res[SAMPLE_BITS-1:0];
            word.final_res = 1'b0;
            expected_words.push_back(word);
        endfunction

        function void take_sample(logic signed [SAMPLE_BITS-1:0] value, logic flag);
            longint x;
            int     queued;

            x      = longint'(value);
            queued = expected_words.size();
            if (!seq_open) begin
                seq_open   = 1'b1;
                run_half   = (reg_half > MAX_HALF) ? MAX_HALF : int'(reg_half);
                run_voiced = reg_voiced;
                for (int i = 0; i < LINE_DEPTH; i++) begin
                    taps[i] = x;
                end
                fill = 1;
            end else begin
                shift_in(x);
                if (fill < run_half + 1) begin
                    fill++;
                end
            end
            if (fill >= run_half + 1) begin
                predict_word();
            end
            if (flag) begin
                for (int k = 1; k <= run_half; k++) begin
                    shift_in(x);
                    if (fill + k >= run_half + 1) begin
                        predict_word();
                    end
                end
                if (expected_words.size() > queued) begin
                    expected_words[expected_words.size() - 1].final_res = 1'b1;
                end
                seq_open = 1'b0;
                fill     = 0;
                sequences++;
            end
        endfunction

        function void check_smoothed(logic signed [SAMPLE_BITS-1:0] got, logic got_final);
            smoothed_word_t want;

            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, smoothed %0d final_res %0b",
                         $time, got, got_final);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got !== want.smoothed) begin
                $display("%0t: smoothed mismatch, expected %0d, actual %0d",
                         $time, want.smoothed, got);
                errors++;
            end
            if (got_final !== want.final_res) begin
                $display("%0t: final_res mismatch, expected %0b, actual %0b",
                         $time, want.final_res, got_final);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index   = mma_pkg::CFG_WINDOW_HALF;
    logic [CFG_W-1:0]              cfg_wdata   = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample    = '0;
    logic                          s_last      = 1'b0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_smoothed;
    logic                          m_final_res;

    pitch_smoother_board board = new();
    bit quiet = 1'b0;
    int ready_hold = 0;
    int idle_cycles = 0;
    int words_sent = 0;

    masked_moving_average #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_smoothed  (m_smoothed),
        .m_final_res (m_final_res)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int r;
        int v;

        r = $urandom_range(0, 99);
        if (r < 55) begin
            v = int'($urandom_range(40 << 12, 600 << 12));
        end else if (r < 68) begin
            v = -int'($urandom_range(0, 1 << 20));
        end else if (r < 85) begin
            v = int'($urandom);
        end else if (r < 95) begin
            case ($urandom_range(0, 4))
                0: v = MOST_POS;
                1: v = -(1 << 23);
                2: v = 0;
                3: v = 1;
                default: v = -1;
            endcase
        end else begin
            v = int'($urandom_range(0, (1 << 23) - 1));
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Result side: check every accepted word and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_smoothed(m_smoothed, m_final_res);
        end
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("masked_moving_average test failed");
            $finish;
        end
    end

    task automatic send_word(input logic signed [SAMPLE_BITS-1:0] value, input logic flag);
        int gap;

        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        s_last   <= flag;
        do @(posedge aclk); while (!s_ready);
        board.take_sample(value, flag);
        words_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] half, input logic voiced);
        cfg_wr_en <= 1'b1;
        cfg_index <= mma_pkg::CFG_WINDOW_HALF;
        cfg_wdata <= half;
        @(posedge aclk);
        board.write_reg(mma_pkg::CFG_WINDOW_HALF, half);
        cfg_index <= mma_pkg::CFG_VOICED_ONLY;
        cfg_wdata <= {{(CFG_W-1){1'b0}}, voiced};
        @(posedge aclk);
        board.write_reg(mma_pkg::CFG_VOICED_ONLY, {{(CFG_W-1){1'b0}}, voiced});
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int phase;
        int seq_count;
        int len;
        int swap_at;
        int random_words;
        logic [CFG_W-1:0] half;
        logic voiced;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default settings straight after reset, with extreme and unvoiced samples.
        send_word(MOST_POS, 1'b0);
        send_word(24'sd0, 1'b0);
        send_word(MOST_NEG, 1'b0);
        send_word(24'sd4096, 1'b0);
        send_word(24'sd409600, 1'b0);
        send_word(-24'sd1, 1'b1);
        drain_results();

        set_config(4'd0, 1'b0);
        send_word(MOST_NEG, 1'b0);
        send_word(MOST_POS, 1'b1);
        send_word(24'sd123, 1'b1);
        drain_results();

        // A tie in the mean of two voiced taps rounds away from zero.
        set_config(4'd1, 1'b1);
        send_word(24'sd1, 1'b0);
        send_word(24'sd2, 1'b0);
        send_word(-24'sd5, 1'b1);
        drain_results();

        // Widest window on a sequence far shorter than it, with negative means.
        set_config(4'd15, 1'b0);
        send_word(MOST_NEG, 1'b0);
        send_word(MOST_NEG + 24'sd1, 1'b0);
        send_word(24'sd5, 1'b1);
        drain_results();

        // A write in the middle of a sequence only applies to the next one.
        set_config(4'd3, 1'b0);
        send_word(24'sd1000, 1'b0);
        send_word(-24'sd3000, 1'b0);
        drain_results();
        set_config(4'd1, 1'b1);
        send_word(24'sd7, 1'b0);
        send_word(24'sd0, 1'b0);
        send_word(24'sd9, 1'b1);
        send_word(-24'sd2, 1'b0);
        send_word(24'sd5, 1'b1);
        drain_results();

        phase = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            case (phase)
                0: begin half = 4'd0;  voiced = 1'b0; end
                1: begin half = 4'd15; voiced = 1'b1; end
                2: begin half = 4'd15; voiced = 1'b0; end
                3: begin half = 4'd0;  voiced = 1'b1; end
                default: begin
                    half   = CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 4)
                                                         : $urandom_range(0, 15));
                    voiced = 1'($urandom_range(0, 1));
                end
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            set_config(half, voiced);
            seq_count = $urandom_range(1, 4);
            repeat (seq_count) begin
                if (random_words < RANDOM_WORDS) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
                    if (len > RANDOM_WORDS - random_words) begin
                        len = RANDOM_WORDS - random_words;
                    end
                    swap_at = ($urandom_range(0, 3) == 0 && len > 1) ?
                              $urandom_range(1, len - 1) : -1;
                    for (int i = 0; i < len; i++) begin
                        if (i == swap_at) begin
                            drain_results();
                            set_config(CFG_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                        end
                        send_word(pick_sample(), i == len - 1);
                        random_words++;
                    end
                end
            end
            drain_results();
            phase++;
        end
        quiet = 1'b0;

        if (board.expected_words.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, board.expected_words.size());
            board.errors += board.expected_words.size();
        end
        $display("Ran %0d sequences of %0d input words: six directed cases, %0d random phases.",
                 board.sequences, words_sent, phase);
        $display("Checked %0d averaged and %0d passed-through words, %0d errors.",
                 board.averaged, board.passed, board.errors);
        if (board.errors == 0) begin
            $display("masked_moving_average test passed");
        end else begin
            $display("masked_moving_average test failed");
        end
        $finish;
    end

endmodule
